@@ src/cswt_pkg.sv @@
// Shared types, codes and character classes for the C source word tokenizer.
package cswt_pkg;

	// Token kind codes carried with every result item.
	localparam logic [2:0] KIND_IDENT     = 3'd0;
	localparam logic [2:0] KIND_STRING    = 3'd1;
	localparam logic [2:0] KIND_CHAR      = 3'd2;
	localparam logic [2:0] KIND_DIRECTIVE = 3'd3;
	localparam logic [2:0] KIND_SINGLE    = 3'd4;
	localparam logic [2:0] KIND_END       = 3'd5;

	// Characters with a special meaning to the scanner.
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_UNDERLINE = 8'h5F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;

	// Register reset value and the smallest usable token length.
	localparam logic [10:0] CFG_RESET = 11'd100;
	localparam int unsigned LIMIT_MIN = 2;

	// Output queue depth; the scanner needs room for two items per step.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Scanner modes, one-hot.
	typedef enum logic [7:0] {
		MODE_IDLE         = 8'b0000_0001,
		MODE_SLASH        = 8'b0000_0010,
		MODE_COMMENT      = 8'b0000_0100,
		MODE_COMMENT_STAR = 8'b0000_1000,
		MODE_IDENT        = 8'b0001_0000,
		MODE_HASH_SPACE   = 8'b0010_0000,
		MODE_QUOTE        = 8'b0100_0000,
		MODE_QUOTE_ESC    = 8'b1000_0000
	} mode_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] token_kind;
		logic       token_last;
	} res_t;

	// Up to two result items produced by one scanner step.
	typedef struct packed {
		logic [1:0] count;
		res_t       r1;
		res_t       r0;
	} push_t;

	// Whitespace: space and the control characters tab to carriage return.
	function automatic logic is_space(input logic [7:0] b);
		return b inside {8'd32, [8'd9:8'd13]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return b inside {[8'd65:8'd90], [8'd97:8'd122]};
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return b inside {[8'd65:8'd90], [8'd97:8'd122], [8'd48:8'd57], CH_UNDERLINE};
	endfunction

endpackage

@@ src/c_source_word_tokenizer_top.sv @@
// Top level of the C source word tokenizer: input register, scanner and output queue.
//
//  channel   direction  tdata         tuser       tlast
//  s_axis    in         in_byte[7:0]  -           end_of_input
//  m_axis    out        out_byte[7:0] token_kind  token_last
//  cfg       in         cfg_wdata = max_token_length, written when cfg_we is high
//
// One byte per cycle while the queue has room: a byte is registered on acceptance and
// scanned from that register, producing up to two items into a four-entry queue. The scanner
// steps while the queue has room for two items, so a slow consumer stalls s_axis_tready.
// Reset clears the scanner to between tokens and empties the queue; max_token_length
// returns to 100.
module c_source_word_tokenizer_top #(
	parameter int unsigned LENGTH_LIMIT_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tlast,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic [2:0]  m_axis_tuser,   // token_kind
	output logic        m_axis_tlast,   // token_last
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata       // max_token_length
);

	logic [10:0]     cfg_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;
	logic            room;
	logic            step;
	cswt_pkg::push_t push;
	cswt_pkg::res_t  out_res;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cswt_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Input register: refilled whenever its item is scanned or it is empty.
	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	cswt_scan #(
		.LENGTH_LIMIT_MAX(LENGTH_LIMIT_MAX)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_limit (cfg_q),
		.step      (step),
		.item_byte (byte_s1),
		.item_end  (end_s1),
		.push      (push)
	);

	cswt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Result item fields onto the output stream.
	assign m_axis_tdata = out_res.out_byte;
	assign m_axis_tuser = out_res.token_kind;
	assign m_axis_tlast = out_res.token_last;

endmodule

@@ src/cswt_scan.sv @@
// Scanner: mode register, held token byte and length count; emits up to two items a step.
module cswt_scan #(
	parameter int unsigned LENGTH_LIMIT_MAX = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [10:0]          cfg_limit,
	input  logic                 step,
	input  logic [7:0]           item_byte,
	input  logic                 item_end,
	output cswt_pkg::push_t      push
);

	localparam int unsigned CW = $clog2(LENGTH_LIMIT_MAX + 1);
	localparam int unsigned LW = (CW > 11) ? CW : 11;

	cswt_pkg::mode_t mode_q, mode_c;
	logic [7:0]      held_q, held_c;
	logic            hvalid_q, hvalid_c;
	logic [7:0]      quote_q, quote_c;
	logic [CW-1:0]   count_q, count_c;
	logic [2:0]      kind_q, kind_c;

	logic [LW-1:0]   limit;
	cswt_pkg::res_t  res0_c, res1_c;
	logic [1:0]      n_c;
	logic            do_finish, do_start, do_push, post_finish;

	// Clamp the configured limit into the usable range.
	always_comb begin
		if (cfg_limit < 11'(cswt_pkg::LIMIT_MIN)) begin
			limit = LW'(cswt_pkg::LIMIT_MIN);
		end else if (LW'(cfg_limit) > LW'(LENGTH_LIMIT_MAX)) begin
			limit = LW'(LENGTH_LIMIT_MAX);
		end else begin
			limit = LW'(cfg_limit);
		end
	end

	// Next state and result items for the current byte.
	always_comb begin
		mode_c      = mode_q;
		held_c      = held_q;
		hvalid_c    = hvalid_q;
		quote_c     = quote_q;
		count_c     = count_q;
		kind_c      = kind_q;
		res0_c      = '0;
		res1_c      = '0;
		n_c         = 2'd0;
		do_finish   = 1'b0;
		do_start    = 1'b0;
		do_push     = 1'b0;
		post_finish = 1'b0;

		if (item_end) begin
			// End of input: flush the held byte, then the end marker.
			if (hvalid_q) begin
				res0_c = '{out_byte: held_q, token_kind: kind_q, token_last: 1'b1};
				res1_c = '{out_byte: 8'd0, token_kind: cswt_pkg::KIND_END, token_last: 1'b1};
				n_c    = 2'd2;
			end else begin
				res0_c = '{out_byte: 8'd0, token_kind: cswt_pkg::KIND_END, token_last: 1'b1};
				n_c    = 2'd1;
			end
			mode_c   = cswt_pkg::MODE_IDLE;
			held_c   = 8'd0;
			hvalid_c = 1'b0;
			quote_c  = 8'd0;
			count_c  = '0;
			kind_c   = cswt_pkg::KIND_IDENT;
		end else begin
			// Decide what this byte does in the current mode.
			case (mode_q)
				cswt_pkg::MODE_SLASH: begin
					if (item_byte == cswt_pkg::CH_STAR) begin
						held_c   = 8'd0;
						hvalid_c = 1'b0;
						count_c  = '0;
						mode_c   = cswt_pkg::MODE_COMMENT;
					end else begin
						do_finish = 1'b1;
						do_start  = 1'b1;
					end
				end
				cswt_pkg::MODE_COMMENT: begin
					if (item_byte == cswt_pkg::CH_STAR) begin
						mode_c = cswt_pkg::MODE_COMMENT_STAR;
					end
				end
				cswt_pkg::MODE_COMMENT_STAR: begin
					if (item_byte == cswt_pkg::CH_SLASH) begin
						mode_c = cswt_pkg::MODE_IDLE;
					end else if (item_byte != cswt_pkg::CH_STAR) begin
						mode_c = cswt_pkg::MODE_COMMENT;
					end
				end
				cswt_pkg::MODE_IDENT: begin
					if (cswt_pkg::is_word(item_byte)) begin
						do_push = 1'b1;
					end else begin
						do_finish = 1'b1;
						do_start  = 1'b1;
					end
				end
				cswt_pkg::MODE_HASH_SPACE: begin
					if (!cswt_pkg::is_space(item_byte)) begin
						mode_c  = cswt_pkg::MODE_IDENT;
						do_push = 1'b1;
					end
				end
				cswt_pkg::MODE_QUOTE: begin
					do_push = 1'b1;
					if (item_byte == quote_q) begin
						mode_c      = cswt_pkg::MODE_IDLE;
						post_finish = 1'b1;
					end else if (item_byte == cswt_pkg::CH_BACKSLASH) begin
						mode_c = cswt_pkg::MODE_QUOTE_ESC;
					end
				end
				cswt_pkg::MODE_QUOTE_ESC: begin
					do_push = 1'b1;
					mode_c  = cswt_pkg::MODE_QUOTE;
				end
				default: begin
					do_start = 1'b1;
				end
			endcase

			// Close the current token ahead of a new one.
			if (do_finish && hvalid_c) begin
				res0_c = '{out_byte: held_c, token_kind: kind_c, token_last: 1'b1};
				n_c    = 2'd1;
			end
			if (do_finish) begin
				held_c   = 8'd0;
				hvalid_c = 1'b0;
				count_c  = '0;
			end

			// Classify the first byte of a new token.
			if (do_start) begin
				mode_c = cswt_pkg::MODE_IDLE;
				if (cswt_pkg::is_space(item_byte)) begin
					mode_c = cswt_pkg::MODE_IDLE;
				end else if (item_byte == cswt_pkg::CH_SLASH) begin
					kind_c  = cswt_pkg::KIND_SINGLE;
					mode_c  = cswt_pkg::MODE_SLASH;
					do_push = 1'b1;
				end else if (item_byte == cswt_pkg::CH_DQUOTE ||
						item_byte == cswt_pkg::CH_SQUOTE) begin
					kind_c  = (item_byte == cswt_pkg::CH_DQUOTE) ? cswt_pkg::KIND_STRING
						: cswt_pkg::KIND_CHAR;
					quote_c = item_byte;
					mode_c  = cswt_pkg::MODE_QUOTE;
					do_push = 1'b1;
				end else if (item_byte == cswt_pkg::CH_HASH) begin
					kind_c  = cswt_pkg::KIND_DIRECTIVE;
					mode_c  = cswt_pkg::MODE_HASH_SPACE;
					do_push = 1'b1;
				end else if (cswt_pkg::is_alpha(item_byte) ||
						item_byte == cswt_pkg::CH_UNDERLINE) begin
					kind_c  = cswt_pkg::KIND_IDENT;
					mode_c  = cswt_pkg::MODE_IDENT;
					do_push = 1'b1;
				end else begin
					if (n_c == 2'd0) begin
						res0_c = '{out_byte: item_byte, token_kind: cswt_pkg::KIND_SINGLE,
							token_last: 1'b1};
					end else begin
						res1_c = '{out_byte: item_byte, token_kind: cswt_pkg::KIND_SINGLE,
							token_last: 1'b1};
					end
					n_c = n_c + 2'd1;
				end
			end

			// Append the byte: release the previously held byte and check the limit.
			if (do_push) begin
				if (hvalid_c) begin
					res0_c = '{out_byte: held_c, token_kind: kind_c, token_last: 1'b0};
					n_c    = 2'd1;
				end
				held_c   = item_byte;
				hvalid_c = 1'b1;
				count_c  = count_c + 1'b1;
				if (LW'(count_c) >= limit) begin
					if (n_c == 2'd0) begin
						res0_c = '{out_byte: held_c, token_kind: kind_c, token_last: 1'b1};
					end else begin
						res1_c = '{out_byte: held_c, token_kind: kind_c, token_last: 1'b1};
					end
					n_c      = n_c + 2'd1;
					held_c   = 8'd0;
					hvalid_c = 1'b0;
					count_c  = '0;
					mode_c   = cswt_pkg::MODE_IDLE;
				end
			end

			// A closing quote ends the token at once.
			if (post_finish && hvalid_c) begin
				if (n_c == 2'd0) begin
					res0_c = '{out_byte: held_c, token_kind: kind_c, token_last: 1'b1};
				end else begin
					res1_c = '{out_byte: held_c, token_kind: kind_c, token_last: 1'b1};
				end
				n_c = n_c + 2'd1;
			end
			if (post_finish) begin
				held_c   = 8'd0;
				hvalid_c = 1'b0;
				count_c  = '0;
			end
		end
	end

	// Scanner state, updated once per consumed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cswt_pkg::MODE_IDLE;
			held_q   <= 8'd0;
			hvalid_q <= 1'b0;
			quote_q  <= 8'd0;
			count_q  <= '0;
			kind_q   <= cswt_pkg::KIND_IDENT;
		end else if (step) begin
			mode_q   <= mode_c;
			held_q   <= held_c;
			hvalid_q <= hvalid_c;
			quote_q  <= quote_c;
			count_q  <= count_c;
			kind_q   <= kind_c;
		end
	end

	assign push.count = step ? n_c : 2'd0;
	assign push.r0    = res0_c;
	assign push.r1    = res1_c;

endmodule

@@ src/cswt_queue.sv @@
// Output queue: takes up to two items a cycle, gives one item a cycle to the stream while it is ready.
module cswt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  cswt_pkg::push_t  push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output cswt_pkg::res_t   out_res
);

	localparam int unsigned DEPTH = cswt_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = $clog2(DEPTH);
	localparam int unsigned FW    = $clog2(DEPTH + 1);

	cswt_pkg::res_t store_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [FW-1:0]  fill_q;
	logic           pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (fill_q != '0);
	assign out_res   = store_q[rd_q];
	// Room for a full step of two items, judged on the registered fill.
	assign room      = (fill_q <= FW'(DEPTH - 2));

	// Entry writes.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			store_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			store_q[wr_q + PW'(1)] <= push.r1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + PW'(push.count);
			rd_q   <= rd_q + PW'(pop);
			fill_q <= fill_q + FW'(push.count) - FW'(pop);
		end
	end

endmodule

@@ tb/sv/tok_stream_checker.sv @@
`timescale 1ns / 1ps
// Token stream checker: predicts the tokenizer's output items and compares them as they leave.
module tok_stream_checker #(
	parameter int unsigned LENGTH_LIMIT_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tlast,   // end_of_input
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // out_byte
	input  logic [2:0]  m_axis_tuser,   // token_kind
	input  logic        m_axis_tlast,   // token_last
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,      // max_token_length
	output int unsigned mismatches,
	output int unsigned tokens_pending
);

	// Predicted token items not yet seen on the output, oldest first.
	cswt_pkg::res_t  tokens_due[$];
	cswt_pkg::res_t  want;
	int unsigned     fault_count = 0;

	// Scanner copy: the newest token byte is held back until its successor shows
	// whether it ends the token.
	cswt_pkg::mode_t scan_state;
	logic [7:0]      lag_byte;
	logic            lag_ok;
	logic [7:0]      quote_open;
	int unsigned     tok_len;
	logic [2:0]      tok_kind;
	logic [10:0]     len_setting;

	assign mismatches = fault_count;

	task automatic flag_fault(input string what);
		$display("%0t ns: token mismatch: %s", $time, what);
		fault_count++;
	endtask

	function automatic logic blank_byte(input logic [7:0] b);
		return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic letter_byte(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic word_byte(input logic [7:0] b);
		return letter_byte(b) || (b >= 8'h30 && b <= 8'h39) || b == cswt_pkg::CH_UNDERLINE;
	endfunction

	// Register values outside the usable range are pulled to the nearest bound.
	function automatic int unsigned token_limit();
		if (len_setting < cswt_pkg::LIMIT_MIN)
			return cswt_pkg::LIMIT_MIN;
		if (len_setting > LENGTH_LIMIT_MAX)
			return LENGTH_LIMIT_MAX;
		return len_setting;
	endfunction

	task automatic due_item(input logic [7:0] b, input logic [2:0] k, input logic last);
		cswt_pkg::res_t t;
		t.out_byte   = b;
		t.token_kind = k;
		t.token_last = last;
		tokens_due.push_back(t);
	endtask

	// Releases the held byte as the final byte of its token.
	task automatic close_token();
		if (lag_ok)
			due_item(lag_byte, tok_kind, 1'b1);
		lag_ok   = 1'b0;
		lag_byte = '0;
		tok_len  = 0;
	endtask

	// Appends a byte to the open token; a token that reaches the limit ends on it.
	task automatic extend_token(input logic [7:0] b, output logic cut);
		if (lag_ok)
			due_item(lag_byte, tok_kind, 1'b0);
		lag_byte = b;
		lag_ok   = 1'b1;
		tok_len++;
		cut = (tok_len >= token_limit());
		if (cut) begin
			close_token();
			scan_state = cswt_pkg::MODE_IDLE;
		end
	endtask

	// Classifies a byte seen between tokens.
	task automatic open_token(input logic [7:0] b);
		logic cut;
		scan_state = cswt_pkg::MODE_IDLE;
		if (blank_byte(b))
			return;
		if (b == cswt_pkg::CH_SLASH) begin
			tok_kind   = cswt_pkg::KIND_SINGLE;
			scan_state = cswt_pkg::MODE_SLASH;
			extend_token(b, cut);
		end else if (b == cswt_pkg::CH_DQUOTE || b == cswt_pkg::CH_SQUOTE) begin
			tok_kind   = (b == cswt_pkg::CH_DQUOTE) ? cswt_pkg::KIND_STRING
				: cswt_pkg::KIND_CHAR;
			quote_open = b;
			scan_state = cswt_pkg::MODE_QUOTE;
			extend_token(b, cut);
		end else if (b == cswt_pkg::CH_HASH) begin
			tok_kind   = cswt_pkg::KIND_DIRECTIVE;
			scan_state = cswt_pkg::MODE_HASH_SPACE;
			extend_token(b, cut);
		end else if (letter_byte(b) || b == cswt_pkg::CH_UNDERLINE) begin
			tok_kind   = cswt_pkg::KIND_IDENT;
			scan_state = cswt_pkg::MODE_IDENT;
			extend_token(b, cut);
		end else begin
			due_item(b, cswt_pkg::KIND_SINGLE, 1'b1);
		end
	endtask

	// One accepted source byte or end of input.
	task automatic scan_source_byte(input logic [7:0] b, input logic eoi);
		logic cut;
		if (eoi) begin
			close_token();
			due_item(8'h00, cswt_pkg::KIND_END, 1'b1);
			scan_state = cswt_pkg::MODE_IDLE;
			quote_open = '0;
			tok_kind   = cswt_pkg::KIND_IDENT;
			return;
		end
		case (scan_state)
			cswt_pkg::MODE_SLASH: begin
				if (b == cswt_pkg::CH_STAR) begin
					// The slash opened a comment and is dropped.
					lag_ok     = 1'b0;
					lag_byte   = '0;
					tok_len    = 0;
					scan_state = cswt_pkg::MODE_COMMENT;
				end else begin
					close_token();
					open_token(b);
				end
			end
			cswt_pkg::MODE_COMMENT: begin
				if (b == cswt_pkg::CH_STAR)
					scan_state = cswt_pkg::MODE_COMMENT_STAR;
			end
			cswt_pkg::MODE_COMMENT_STAR: begin
				if (b == cswt_pkg::CH_SLASH)
					scan_state = cswt_pkg::MODE_IDLE;
				else if (b != cswt_pkg::CH_STAR)
					scan_state = cswt_pkg::MODE_COMMENT;
			end
			cswt_pkg::MODE_IDENT: begin
				if (word_byte(b)) begin
					extend_token(b, cut);
				end else begin
					close_token();
					open_token(b);
				end
			end
			cswt_pkg::MODE_HASH_SPACE: begin
				if (!blank_byte(b)) begin
					scan_state = cswt_pkg::MODE_IDENT;
					extend_token(b, cut);
				end
			end
			cswt_pkg::MODE_QUOTE: begin
				if (b == quote_open) begin
					extend_token(b, cut);
					if (!cut)
						close_token();
					scan_state = cswt_pkg::MODE_IDLE;
				end else if (b == cswt_pkg::CH_BACKSLASH) begin
					extend_token(b, cut);
					if (!cut)
						scan_state = cswt_pkg::MODE_QUOTE_ESC;
				end else begin
					extend_token(b, cut);
				end
			end
			cswt_pkg::MODE_QUOTE_ESC: begin
				extend_token(b, cut);
				if (!cut)
					scan_state = cswt_pkg::MODE_QUOTE;
			end
			default: begin
				open_token(b);
			end
		endcase
	endtask

	// Outputs are checked before the inputs of the same edge are predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state  = cswt_pkg::MODE_IDLE;
			lag_byte    = '0;
			lag_ok      = 1'b0;
			quote_open  = '0;
			tok_len     = 0;
			tok_kind    = cswt_pkg::KIND_IDENT;
			len_setting = cswt_pkg::CFG_RESET;
			tokens_due.delete();
			tokens_pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (tokens_due.size() == 0) begin
					flag_fault($sformatf("unexpected item byte %02h kind %0d last %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want = tokens_due.pop_front();
					if (m_axis_tdata !== want.out_byte)
						flag_fault($sformatf("byte %02h, predicted %02h",
							m_axis_tdata, want.out_byte));
					if (m_axis_tuser !== want.token_kind)
						flag_fault($sformatf("kind %0d, predicted %0d (byte %02h)",
							m_axis_tuser, want.token_kind, want.out_byte));
					if (m_axis_tlast !== want.token_last)
						flag_fault($sformatf("last %0b, predicted %0b (byte %02h)",
							m_axis_tlast, want.token_last, want.out_byte));
				end
			end
			if (cfg_we)
				len_setting = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				scan_source_byte(s_axis_tdata, s_axis_tlast);
			tokens_pending <= tokens_due.size();
		end
	end

endmodule

@@ tb/sv/tb_c_source_word_tokenizer_top.sv @@
`timescale 1ns / 1ps
// Testbench top: feeds C source bytes and limit settings to the tokenizer and gives the verdict.
module tb_c_source_word_tokenizer_top;

	localparam int unsigned LENGTH_LIMIT_MAX = 1024;
	localparam int unsigned PHASE_ITEMS      = 78;
	localparam int unsigned LONG_IDENT_LEN   = 40;
	localparam int unsigned SINK_HOLD_CYCLES = 200;
	localparam int unsigned SETTLE_CYCLES    = 4;
	localparam int unsigned TAIL_CYCLES      = 8;
	localparam int unsigned WATCHDOG_LIMIT   = 5000;

	// Limit settings visited during the run.
	localparam logic [10:0] LEN_SHORT     = 11'd5;
	localparam logic [10:0] LEN_MIN       = 11'd2;
	localparam logic [10:0] LEN_BELOW_MIN = 11'd0;
	localparam logic [10:0] LEN_MAX       = 11'd1024;
	localparam logic [10:0] LEN_ALL_ONES  = 11'd2047;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // in_byte
	logic        s_axis_tlast = 1'b0; // end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // out_byte
	logic [2:0]  m_axis_tuser;        // token_kind
	logic        m_axis_tlast;        // token_last
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;      // max_token_length

	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	logic        hold_sink = 1'b0;
	int unsigned stall_cycles = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches;
	int unsigned tokens_pending;

	// Bytes of the source fragment about to be sent.
	logic [7:0]  frag[$];
	logic        frag_is_end;

	c_source_word_tokenizer_top #(
		.LENGTH_LIMIT_MAX(LENGTH_LIMIT_MAX)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	tok_stream_checker #(
		.LENGTH_LIMIT_MAX(LENGTH_LIMIT_MAX)
	) token_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.tokens_pending(tokens_pending)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Consumer: random back-pressure, or a long hold-off while hold_sink is raised.
	always @(posedge clk) begin
		if (hold_sink && stall_cycles < SINK_HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			stall_cycles  <= stall_cycles + 1;
		end else begin
			if (!hold_sink)
				stall_cycles <= 0;
			m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offers one item, with random gaps beforehand, and returns once it is taken.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eoi;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// Stops offering and waits until every predicted item has left the block.
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [10:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [7:0] ident_start();
		int unsigned r;
		r = $urandom_range(0, 52);
		if (r == 52)
			return cswt_pkg::CH_UNDERLINE;
		return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
	endfunction

	function automatic logic [7:0] ident_char();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 8'(8'h30 + $urandom_range(0, 9));
		return ident_start();
	endfunction

	// Builds one piece of source: mostly well-formed tokens, some comments and
	// whitespace, and some raw noise.
	task automatic build_fragment();
		int unsigned pick;
		int unsigned n;
		int unsigned r;
		logic [7:0]  q;
		string       ops;
		ops = "+-*/=;,(){}[]<>0123456789!&|%.?:~^";
		frag.delete();
		frag_is_end = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 26) begin
			// Identifier.
			frag.push_back(ident_start());
			n = $urandom_range(0, 10);
			repeat (n) frag.push_back(ident_char());
		end else if (pick < 40) begin
			// String or character literal with escapes, sometimes left open.
			q = $urandom_range(0, 1) ? cswt_pkg::CH_DQUOTE : cswt_pkg::CH_SQUOTE;
			frag.push_back(q);
			n = $urandom_range(0, 6);
			repeat (n) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					frag.push_back(cswt_pkg::CH_BACKSLASH);
					frag.push_back(8'($urandom_range(0, 255)));
				end else if (r == 1) begin
					frag.push_back((q == cswt_pkg::CH_DQUOTE) ? cswt_pkg::CH_SQUOTE
						: cswt_pkg::CH_DQUOTE);
				end else begin
					frag.push_back(8'($urandom_range(32, 126)));
				end
			end
			if ($urandom_range(0, 9) != 0)
				frag.push_back(q);
		end else if (pick < 50) begin
			// Comment with stray stars and slashes inside.
			frag.push_back(cswt_pkg::CH_SLASH);
			frag.push_back(cswt_pkg::CH_STAR);
			n = $urandom_range(0, 6);
			repeat (n) begin
				r = $urandom_range(0, 3);
				frag.push_back((r == 0) ? cswt_pkg::CH_STAR : (r == 1) ? cswt_pkg::CH_SLASH :
					8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 7) != 0) begin
				frag.push_back(cswt_pkg::CH_STAR);
				frag.push_back(cswt_pkg::CH_SLASH);
			end
		end else if (pick < 58) begin
			// Directive: hash, optional blanks, any byte, then word characters.
			frag.push_back(cswt_pkg::CH_HASH);
			n = $urandom_range(0, 2);
			repeat (n) frag.push_back(8'h20);
			frag.push_back(8'($urandom_range(0, 255)));
			n = $urandom_range(0, 6);
			repeat (n) frag.push_back(ident_char());
		end else if (pick < 70) begin
			// Whitespace only.
			n = $urandom_range(1, 3);
			repeat (n) frag.push_back($urandom_range(0, 3) ? 8'h20 :
				8'($urandom_range(9, 13)));
		end else if (pick < 84) begin
			// Operators, digits and lone slashes.
			n = $urandom_range(1, 3);
			repeat (n) frag.push_back(ops[$urandom_range(0, ops.len() - 1)]);
		end else if (pick < 98) begin
			// Raw bytes over the whole range.
			n = $urandom_range(1, 4);
			repeat (n) frag.push_back(8'($urandom_range(0, 255)));
		end else begin
			frag_is_end = 1'b1;
		end
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned fed;
		fed = 0;
		while (fed < budget) begin
			build_fragment();
			if (frag_is_end)
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			foreach (frag[i])
				send_byte(frag[i], 1'b0);
			fed += frag_is_end ? 1 : frag.size();
		end
	endtask

	// Stimulus and verdict.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identifier, digit, empty comment, escaped quotes, directive
		// with a blank after the hash, and a slash right before end of input.
		src_idle_pct = 25;
		snk_idle_pct <= 62;
		send_text("_a9 7/**/\"a\\\"b\"# x'\\''/");
		send_byte(8'hFF, 1'b1);
		wait_results();

		// Consumer held off while the producer keeps offering, so the block backs up.
		hold_sink <= 1'b1;
		send_text("int main ( void ) { return x_1 ; } /* c */ a\"q\" ;");
		hold_sink <= 1'b0;
		wait_results();

		write_limit(LEN_SHORT);
		run_random(PHASE_ITEMS);
		wait_results();

		// Limit lowered below the length of a token that is still open.
		write_limit(LEN_MAX);
		send_text("abcdef");
		wait_results();
		write_limit(LEN_MIN);
		send_text("gh ");
		wait_results();

		src_idle_pct = 62;
		snk_idle_pct <= 25;
		write_limit(LEN_BELOW_MIN);
		run_random(PHASE_ITEMS);
		wait_results();

		// An over-range setting acts as the largest limit, so a long identifier stays whole.
		src_idle_pct = 0;
		snk_idle_pct <= 0;
		write_limit(LEN_ALL_ONES);
		for (int i = 0; i < LONG_IDENT_LEN; i++)
			send_byte(8'(8'h61 + i % 26), 1'b0);
		send_byte(8'h20, 1'b0);
		wait_results();

		write_limit(LEN_MAX);
		run_random(PHASE_ITEMS);
		send_byte(8'h00, 1'b1);
		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
src/cswt_pkg.sv
src/cswt_scan.sv
src/cswt_queue.sv
src/c_source_word_tokenizer_top.sv
tb/sv/tok_stream_checker.sv
tb/sv/tb_c_source_word_tokenizer_top.sv
